// ===== sv/xoshiro256ss_generator_defines.svh =====
// ----------------------------------------------------------------------------
// xoshiro256ss_generator_defines.svh
// Assertion macros shared by the generator's RTL files.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256SS_GENERATOR_DEFINES_SVH
`define XOSHIRO256SS_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define XSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define XSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define XSS_ASSERT_IMPL(lbl, ante, cons, msg)
`define XSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/xss_pkg.sv =====
// ----------------------------------------------------------------------------
// xss_pkg
// Shared types and constants of the xoshiro256** generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xss_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned NumWords = 4;
  localparam int unsigned WordIdxW = $clog2(NumWords);

  // SplitMix64 constants.
  localparam logic [WordW-1:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMulB = 64'h94d049bb133111eb;
  localparam int unsigned MixShiftA = 30;
  localparam int unsigned MixShiftB = 27;
  localparam int unsigned MixShiftC = 31;

  // xoshiro256** constants.
  localparam int unsigned UpdShift = 17;
  localparam int unsigned UpdRot = 45;
  localparam int unsigned OutRot = 7;

  // Shared multiplier: one digit of the factor per cycle.
  localparam int unsigned MulDigitW = 16;
  localparam int unsigned MulSteps = WordW / MulDigitW;
  localparam int unsigned MulCntW = $clog2(MulSteps);
  localparam int unsigned MulProdW = WordW + MulDigitW;

  // Command codes.
  localparam logic CmdDraw = 1'b0;
  localparam logic CmdSeed = 1'b1;

  typedef struct packed {
    logic             command;
    logic [WordW-1:0] seed_value;
  } cmd_t;

  typedef struct packed {
    logic [WordW-1:0] random_word;
  } rnd_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] operand;
    logic [WordW-1:0] factor;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== sv/xss_stream_if.sv =====
// ----------------------------------------------------------------------------
// xss_stream_if
// Valid/ready channel that carries one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface xss_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== sv/xss_mul.sv =====
// ----------------------------------------------------------------------------
// xss_mul
// Iterative 64-bit multiplier, product modulo 2^64, one 16-bit digit of the
// factor per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xoshiro256ss_generator_defines.svh"

module xss_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xss_pkg::mul_req_t req_i,
  output xss_pkg::mul_rsp_t      rsp_o
);

  localparam logic [xss_pkg::MulCntW-1:0] LastStep =
    xss_pkg::MulCntW'(xss_pkg::MulSteps - 1);

  logic                        busy_q;
  logic                        done_q;
  logic [xss_pkg::MulCntW-1:0] cnt_q;
  logic [xss_pkg::WordW-1:0]   opa_q;
  logic [xss_pkg::WordW-1:0]   fac_q;
  logic [xss_pkg::WordW-1:0]   acc_q;
  logic [xss_pkg::WordW-1:0]   acc_d;
  logic [xss_pkg::MulProdW-1:0] part;

  // The operand moves up one digit per step while the factor moves down,
  // so each partial product lands at its proper weight.
  assign part = xss_pkg::MulProdW'(opa_q) *
                xss_pkg::MulProdW'(fac_q[xss_pkg::MulDigitW-1:0]);
  assign acc_d = acc_q + part[xss_pkg::WordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      opa_q <= req_i.operand;
      fac_q <= req_i.factor;
      acc_q <= '0;
    end else if (busy_q) begin
      opa_q <= opa_q << xss_pkg::MulDigitW;
      fac_q <= fac_q >> xss_pkg::MulDigitW;
      acc_q <= acc_d;
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

  `XSS_ASSERT_IMPL(a_no_restart, req_i.start, !busy_q, "multiplier restarted while busy")
  `XSS_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")
  `XSS_ASSERT_NEXT(a_done_after_last, busy_q && (cnt_q == LastStep) && !req_i.start,
                   done_q && !busy_q, "no done after the last step")

endmodule

`default_nettype wire

// ===== sv/xoshiro256ss_generator.sv =====
// ----------------------------------------------------------------------------
// xoshiro256ss_generator
// xoshiro256** pseudo-random word generator with SplitMix64 seeding.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                         Handshake
//   cmd_i    in   command (1b), seed_value (64b)  valid/ready
//   rnd_o    out  random_word (64b)               valid/ready
//
// In a draw item, the accept cycle forms s1*5; then, in StDraw, the block
// forms rotl(s1*5,7)*9, advances the state and loads the output register.
// A seed item runs eight 64-bit multiplies by the SplitMix64 constants on
// the shared digit-serial multiplier. No result is given for a seed item.
// Reset clears the four state words, so draws before the first seed give 0.
// A draw waits in StDraw while the output register holds a result
// that has not been taken; a seed item can be taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xoshiro256ss_generator_defines.svh"

module xoshiro256ss_generator (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  xss_stream_if.sink   cmd_i,
  xss_stream_if.source rnd_o
);

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDraw = 2'd1;
  localparam logic [1:0] StMixA = 2'd2;
  localparam logic [1:0] StMixB = 2'd3;

  localparam logic [xss_pkg::WordIdxW-1:0] LastWord =
    xss_pkg::WordIdxW'(xss_pkg::NumWords - 1);

  localparam int unsigned W = xss_pkg::WordW;

  logic [1:0] state_q, state_d;

  // Generator state words.
  logic [xss_pkg::NumWords-1:0][W-1:0] words_q, words_d;

  // Seeding: running SplitMix64 sum and the index of the word being built.
  logic [W-1:0]                 sum_q, sum_d;
  logic [xss_pkg::WordIdxW-1:0] idx_q, idx_d;

  // Draw: s1*5 held from the accept cycle of a draw into StDraw.
  logic [W-1:0] times5_q, times5_d;

  // Output register.
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_word_q, out_word_d;

  xss_pkg::mul_req_t mul_req;
  xss_pkg::mul_rsp_t mul_rsp;

  logic         accept;
  logic         out_free;
  logic [W-1:0] sum_next;
  logic [W-1:0] mix_b_in;
  logic [W-1:0] mix_out;
  logic [W-1:0] rot7;

  // Draw update terms.
  logic [W-1:0] s0, s1, s2, s3;
  logic [W-1:0] n0, n1, n2, n3;

  xss_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign cmd_i.ready = (state_q == StIdle);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || rnd_o.ready;

  assign s0 = words_q[0];
  assign s1 = words_q[1];
  assign s2 = words_q[2];
  assign s3 = words_q[3];

  // xoshiro256 state advance, written as one set of xors per word.
  assign n2 = s2 ^ s0;
  assign n3 = s3 ^ s1;
  assign n1 = s1 ^ n2;
  assign n0 = s0 ^ n3;

  // Scrambler: rotl(s1*5, 7)*9 with both multiplies as shift-adds.
  assign rot7 = {times5_q[W-1-xss_pkg::OutRot:0], times5_q[W-1:W-xss_pkg::OutRot]};

  // SplitMix64 mixing steps around the two multiplies.
  assign mix_b_in = mul_rsp.product ^ (mul_rsp.product >> xss_pkg::MixShiftB);
  assign mix_out  = mul_rsp.product ^ (mul_rsp.product >> xss_pkg::MixShiftC);

  // The sum for the next word: the seed plus the step in idle, else the running sum plus the step.
  assign sum_next = (state_q == StIdle) ? cmd_i.payload.seed_value + xss_pkg::GoldenStep
                                        : sum_q + xss_pkg::GoldenStep;

  always_comb begin
    state_d     = state_q;
    words_d     = words_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    times5_d    = times5_q;
    out_valid_d = out_valid_q && !rnd_o.ready;
    out_word_d  = out_word_q;

    mul_req.start   = 1'b0;
    mul_req.operand = sum_next ^ (sum_next >> xss_pkg::MixShiftA);
    mul_req.factor  = xss_pkg::MixMulA;

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i.payload.command == xss_pkg::CmdSeed) begin
            // First word: start (z ^ z>>30) * A right away.
            sum_d         = sum_next;
            idx_d         = '0;
            mul_req.start = 1'b1;
            state_d       = StMixA;
          end else begin
            times5_d = s1 + (s1 << 2);
            state_d  = StDraw;
          end
        end
      end
      StDraw: begin
        if (out_free) begin
          out_word_d  = rot7 + (rot7 << 3);
          out_valid_d = 1'b1;
          words_d[0]  = n0;
          words_d[1]  = n1;
          words_d[2]  = n2 ^ (s1 << xss_pkg::UpdShift);
          words_d[3]  = {n3[W-1-xss_pkg::UpdRot:0], n3[W-1:W-xss_pkg::UpdRot]};
          state_d     = StIdle;
        end
      end
      StMixA: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = mix_b_in;
          mul_req.factor  = xss_pkg::MixMulB;
          state_d         = StMixB;
        end
      end
      StMixB: begin
        if (mul_rsp.done) begin
          words_d[idx_q] = mix_out;
          if (idx_q == LastWord) begin
            state_d = StIdle;
          end else begin
            // Next word: advance the sum and start its first multiply.
            sum_d         = sum_next;
            idx_d         = idx_q + 1'b1;
            mul_req.start = 1'b1;
            state_d       = StMixA;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      words_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      words_q     <= words_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    idx_q      <= idx_d;
    times5_q   <= times5_d;
    out_word_q <= out_word_d;
  end

  assign rnd_o.valid               = out_valid_q;
  assign rnd_o.payload.random_word = out_word_q;

  `XSS_ASSERT_NEXT(a_draw_stall, (state_q == StDraw) && out_valid_q && !rnd_o.ready,
                   (state_q == StDraw) && $stable(words_q), "draw advanced while output full")
  `XSS_ASSERT_IMPL(a_mul_idle_when_ready, state_q == StIdle, !mul_rsp.busy && !mul_rsp.done,
                   "multiplier active while the sequencer is idle")
  `XSS_ASSERT_NEXT(a_seed_ends, (state_q == StMixB) && mul_rsp.done && (idx_q == LastWord),
                   state_q == StIdle, "seeding did not end after the last word")

endmodule

`default_nettype wire

// ===== dv/tb_xoshiro256ss_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xoshiro256ss_generator
// Self-checking bench for the xoshiro256** generator with SplitMix64 seeding.
// A queue of seed and draw items feeds a clocked driver. Each accepted item
// updates a local copy of the 256-bit state, and each draw queues the word
// it should return. A clocked monitor compares every returned word with the
// oldest queued one. Random idle and stall bursts cover every phase of the
// draw and seed sequences, and the tail of the run goes at full rate.
// ----------------------------------------------------------------------------

module tb_xoshiro256ss_generator;

  // SplitMix64 constants, written out independently of the package copies so
  // that a wrong package value shows up as a mismatch.
  localparam logic [63:0] SM_INCREMENT = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL_1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL_2 = 64'h94d049bb133111eb;

  localparam int NUM_RANDOM_ITEMS = 1850;
  // Once no more than this many items remain, no new idle or stall burst starts.
  localparam int CALM_ITEMS = 150;
  // The limit leaves a wide margin over the longest quiet stretch that a seed
  // item and a stall or an idle burst can cause.
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_REPORTS = 10;

  logic clk_i;
  logic rst_ni;

  xss_stream_if #(.payload_t(xss_pkg::cmd_t)) cmd_if ();
  xss_stream_if #(.payload_t(xss_pkg::rnd_t)) rnd_if ();

  xoshiro256ss_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rnd_o  (rnd_if)
  );

  // Items still to be offered, words still to be returned, and the bench's
  // own copy of the generator state.
  xss_pkg::cmd_t pending_cmds[$];
  logic [63:0]   expected_words[$];
  logic [63:0]   gen_state[4];

  int mismatch_cnt;
  int accepted_cnt;
  int quiet_cycles;
  int gap_left;
  int stall_left;
  // Chance in percent that a new idle or stall burst starts. It changes every
  // 64 accepted items, so some stretches run with no idling at all.
  int pace_pct;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // SplitMix64 output function applied to one running sum.
  function automatic logic [63:0] splitmix_mix(logic [63:0] z);
    logic [63:0] t;
    t = (z ^ (z >> 30)) * SM_MUL_1;
    t = (t ^ (t >> 27)) * SM_MUL_2;
    return t ^ (t >> 31);
  endfunction

  // Applies one accepted item to the state copy. A seed refills all four
  // words from the SplitMix64 sequence; a draw queues the scrambled word and
  // then runs the xoshiro256 update.
  task automatic advance_generator(xss_pkg::cmd_t item);
    logic [63:0] sum;
    logic [63:0] word;
    logic [63:0] carry_bits;
    sum = item.seed_value;
    if (item.command == xss_pkg::CmdSeed) begin
      for (int i = 0; i < 4; i++) begin
        sum = sum + SM_INCREMENT;
        gen_state[i] = splitmix_mix(sum);
      end
    end else begin
      word = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
      carry_bits = gen_state[1] << 17;
      gen_state[2] = gen_state[2] ^ gen_state[0];
      gen_state[3] = gen_state[3] ^ gen_state[1];
      gen_state[1] = gen_state[1] ^ gen_state[2];
      gen_state[0] = gen_state[0] ^ gen_state[3];
      gen_state[2] = gen_state[2] ^ carry_bits;
      gen_state[3] = rotl64(gen_state[3], 45);
      expected_words.push_back(word);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_cmd(logic command, logic [63:0] seed);
    xss_pkg::cmd_t item;
    item.command = command;
    item.seed_value = seed;
    pending_cmds.push_back(item);
  endtask

  function automatic logic [63:0] random_word64();
    return {$urandom(), $urandom()};
  endfunction

  // Half of the seeds are full random words; the rest are sparse and dense patterns
  // so that carries through the increment are exercised too.
  function automatic logic [63:0] random_seed();
    logic [63:0] s;
    case ($urandom_range(0, 7))
      0: s = 64'(1) << $urandom_range(0, 63);
      1: s = ~(64'(1) << $urandom_range(0, 63));
      2: s = 64'($urandom_range(0, 255));
      3: s = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 255));
      default: s = random_word64();
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset is held at the start of the run and never asserted again. The
  // driver and the monitor hold the channel inputs low while it is asserted.
  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: offers the pending items on the command channel. A new item is
  // only put up once the previous one is taken, and valid stays high until
  // it is. The prediction runs at the edge where the item is accepted.
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.payload <= '0;
      gap_left = 0;
      accepted_cnt = 0;
      pace_pct = 0;
      for (int i = 0; i < 4; i++) begin
        gen_state[i] = '0;
      end
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        advance_generator(cmd_if.payload);
        accepted_cnt++;
        if (accepted_cnt % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: pace_pct = 0;
            1: pace_pct = 5;
            2: pace_pct = 15;
            default: pace_pct = 35;
          endcase
        end
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() > CALM_ITEMS &&
                     $urandom_range(0, 99) < pace_pct) begin
          // This cycle is the first of the burst.
          gap_left = $urandom_range(1, 16) - 1;
          cmd_if.valid <= 1'b0;
        end else begin
          cmd_if.valid <= 1'b1;
          cmd_if.payload <= pending_cmds.pop_front();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes the returned words, with random stall bursts, and checks
  // each one against the oldest expected word.
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_if.ready <= 1'b0;
      stall_left = 0;
      mismatch_cnt = 0;
    end else begin
      if (rnd_if.valid && rnd_if.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("[%0t] unexpected random_word %h with none pending",
                     $realtime, rnd_if.payload.random_word);
          end
        end else begin
          logic [63:0] want;
          want = expected_words.pop_front();
          if (rnd_if.payload.random_word !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("[%0t] random_word mismatch: expected %h, actual %h",
                       $realtime, want, rnd_if.payload.random_word);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rnd_if.ready <= 1'b0;
      end else if (pending_cmds.size() > CALM_ITEMS &&
                   $urandom_range(0, 99) < pace_pct) begin
        stall_left = $urandom_range(1, 16) - 1;
        rnd_if.ready <= 1'b0;
      end else begin
        rnd_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long stretch with no accepted item on either channel means
  // the block has hung.
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (rnd_if.valid && rnd_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------

  initial begin
    // Directed part. Draws before any seed must return zero whatever the
    // seed field holds, since the all-zero state never moves.
    queue_cmd(xss_pkg::CmdDraw, 64'hffff_ffff_ffff_ffff);
    queue_cmd(xss_pkg::CmdDraw, 64'h0);
    queue_cmd(xss_pkg::CmdDraw, 64'h5555_5555_5555_5555);
    // Smallest seed, then a few draws from it.
    queue_cmd(xss_pkg::CmdSeed, 64'h0);
    queue_cmd(xss_pkg::CmdDraw, 64'h0);
    queue_cmd(xss_pkg::CmdDraw, 64'hffff_ffff_ffff_ffff);
    queue_cmd(xss_pkg::CmdDraw, 64'haaaa_aaaa_aaaa_aaaa);
    // Largest seed: the running sum wraps on the very first increment.
    queue_cmd(xss_pkg::CmdSeed, 64'hffff_ffff_ffff_ffff);
    queue_cmd(xss_pkg::CmdDraw, 64'h1);
    queue_cmd(xss_pkg::CmdDraw, 64'h8000_0000_0000_0000);
    // Seeds back to back, the last one wins.
    queue_cmd(xss_pkg::CmdSeed, 64'h1);
    queue_cmd(xss_pkg::CmdSeed, 64'h8000_0000_0000_0000);
    queue_cmd(xss_pkg::CmdSeed, 64'h5555_5555_5555_5555);
    queue_cmd(xss_pkg::CmdDraw, 64'h0);
    queue_cmd(xss_pkg::CmdDraw, 64'h0);
    queue_cmd(xss_pkg::CmdDraw, 64'h0);
    // A seed whose sum lands exactly on zero after one increment.
    queue_cmd(xss_pkg::CmdSeed, 64'h0 - SM_INCREMENT);
    queue_cmd(xss_pkg::CmdDraw, 64'h7fff_ffff_ffff_ffff);
    queue_cmd(xss_pkg::CmdDraw, 64'hffff_ffff_0000_0000);
    queue_cmd(xss_pkg::CmdSeed, 64'haaaa_aaaa_aaaa_aaaa);
    queue_cmd(xss_pkg::CmdDraw, 64'h0000_0000_ffff_ffff);
    queue_cmd(xss_pkg::CmdDraw, 64'h0);

    // Random part: mostly runs of draws between occasional reseeds, with a
    // random seed field on every draw since the block must ignore it.
    for (int n = 0; n < NUM_RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 4) begin
        queue_cmd(xss_pkg::CmdSeed, random_seed());
      end else begin
        queue_cmd(xss_pkg::CmdDraw, random_word64());
      end
    end

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    // Wait until every item has been taken and every word has come back.
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    // Let a late spurious result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== xoshiro256ss_generator.f =====
+incdir+sv
sv/xss_pkg.sv
sv/xss_stream_if.sv
sv/xss_mul.sv
sv/xoshiro256ss_generator.sv
dv/tb_xoshiro256ss_generator.sv
